// ===== rtl/core/mrftg_pkg.sv =====
// ----------------------------------------------------------------------------
// mrftg_pkg: shared definitions for the multi-rate frame tick generator
// Channel codes, widths and the fixed pull-down pattern tables.
// ----------------------------------------------------------------------------
package mrftg_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W         = 3;
   localparam int CNT_W        = 6;
   localparam int IDX_W        = 5;
   localparam int MASK_W       = 8;

   localparam int DEFAULT_CHANNELS = 8;

   localparam logic [MASK_W-1:0] ENABLE_RESET = 8'hFF;

   localparam logic [CH_W-1:0] CH_23976 = 3'd0;
   localparam logic [CH_W-1:0] CH_24    = 3'd1;
   localparam logic [CH_W-1:0] CH_25    = 3'd2;
   localparam logic [CH_W-1:0] CH_2997  = 3'd3;
   localparam logic [CH_W-1:0] CH_30    = 3'd4;
   localparam logic [CH_W-1:0] CH_48    = 3'd5;
   localparam logic [CH_W-1:0] CH_60    = 3'd6;
   localparam logic [CH_W-1:0] CH_100   = 3'd7;

   // number of frames in one pattern cycle
   function automatic logic [IDX_W-1:0] rate_len(input logic [CH_W-1:0] ch);
      logic [IDX_W-1:0] len;
      len = 5'd1;
      case (ch)
         CH_23976: len = 5'd24;
         CH_24:    len = 5'd3;
         CH_25:    len = 5'd1;
         CH_2997:  len = 5'd30;
         CH_30:    len = 5'd3;
         CH_48:    len = 5'd6;
         CH_60:    len = 5'd3;
         CH_100:   len = 5'd1;
         default:  len = 5'd1;
      endcase
      return len;
   endfunction

   // milliseconds of frame idx in the pull-down pattern of channel ch
   function automatic logic [CNT_W-1:0] pattern_entry(input logic [CH_W-1:0] ch,
                                                      input logic [IDX_W-1:0] idx);
      logic [CNT_W-1:0] ms;
      ms = 6'd10;
      case (ch)
         CH_23976: begin
            case (idx) inside
               5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20: ms = 6'd41;
               default: ms = 6'd42;
            endcase
         end
         CH_24:    ms = (idx == 5'd2) ? 6'd41 : 6'd42;
         CH_25:    ms = 6'd40;
         CH_2997: begin
            case (idx) inside
               5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23, 5'd26,
               5'd28, 5'd29: ms = 6'd34;
               default: ms = 6'd33;
            endcase
         end
         CH_30:    ms = (idx == 5'd2) ? 6'd34 : 6'd33;
         CH_48:    ms = (idx == 5'd5) ? 6'd20 : 6'd21;
         CH_60:    ms = (idx == 5'd2) ? 6'd16 : 6'd17;
         CH_100:   ms = 6'd10;
         default:  ms = 6'd10;
      endcase
      return ms;
   endfunction

endpackage

// ===== rtl/core/multi_rate_frame_tick_generator.sv =====
// ----------------------------------------------------------------------------
// multi_rate_frame_tick_generator: frame event mask from millisecond ticks
// Per-channel down-counters reloaded from fixed pull-down patterns.
// ----------------------------------------------------------------------------
// One beat goes in per millisecond tick and one beat comes out for it, carrying
// a bit per frame-rate channel (23.976, 24, 25, 29.97, 30, 48, 60, 100 fps)
// that is set when that channel starts a frame on this tick and is enabled in
// csr_channel_enable. For every input beat, all channel counters decrement and
// reload in parallel, and the mask lands in the output register
// on the edge that accepts the beat. A new beat is taken each cycle the output
// register is empty or being drained. A beat with req_tick low yields an all
// zero mask and leaves the counters alone. Disabled channels keep counting.
// Bits at and above CHANNELS read zero.
module multi_rate_frame_tick_generator #(
   parameter int CHANNELS = mrftg_pkg::DEFAULT_CHANNELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_tick,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mrftg_pkg::MASK_W-1:0] rsp_fired_mask,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mrftg_pkg::MASK_W-1:0] csr_channel_enable
);

   logic [mrftg_pkg::MASK_W-1:0] enable_ff;
   logic                         rsp_valid_ff;
   logic [mrftg_pkg::MASK_W-1:0] mask_ff;
   logic [mrftg_pkg::MASK_W-1:0] mask_in;
   logic                         accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   genvar c;
   generate
      for (c = 0; c < mrftg_pkg::MAX_CHANNELS; c++) begin : g_ch
         if (c < CHANNELS) begin : g_live
            localparam logic [mrftg_pkg::CH_W-1:0] CH = mrftg_pkg::CH_W'(c);

            logic [mrftg_pkg::CNT_W-1:0] count_ff;
            logic [mrftg_pkg::CNT_W-1:0] count_in;
            logic [mrftg_pkg::IDX_W-1:0] index_ff;
            logic [mrftg_pkg::IDX_W-1:0] index_in;
            logic [mrftg_pkg::CNT_W-1:0] dec;
            logic [mrftg_pkg::IDX_W-1:0] inc;
            logic                        fire;

            assign dec  = count_ff - 1'b1;
            assign inc  = index_ff + 1'b1;
            assign fire = req_tick && (dec == '0);

            always_comb begin
               index_in = index_ff;
               count_in = count_ff;
               if (req_tick) begin
                  count_in = dec;
                  if (fire) begin
                     index_in = (inc >= mrftg_pkg::rate_len(CH)) ? '0 : inc;
                     count_in = mrftg_pkg::pattern_entry(CH, index_in);
                  end
               end
            end

            assign mask_in[c] = fire && enable_ff[c];

            always_ff @(posedge clock) begin
               if (reset) begin
                  index_ff <= '0;
                  count_ff <= mrftg_pkg::pattern_entry(CH, '0);
               end else if (accept) begin
                  index_ff <= index_in;
                  count_ff <= count_in;
               end
            end
         end else begin : g_none
            assign mask_in[c] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= mrftg_pkg::ENABLE_RESET;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_channel_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_mask = mask_ff;

endmodule

// ===== verif/multi_rate_frame_tick_generator_tb.sv =====
// ----------------------------------------------------------------------------
// multi_rate_frame_tick_generator_tb: self-checking bench for the tick generator
// Runs the eight pull-down counters alongside the block and compares every
// fired_mask beat in order. Covers idle ticks, the first frames after reset,
// several enable masks, random gaps and stalls on both channels, a long output
// hold-off, and a run of steady ticks under light idling on both sides.
// ----------------------------------------------------------------------------
module multi_rate_frame_tick_generator_tb;

   localparam int NUM_CH     = mrftg_pkg::DEFAULT_CHANNELS;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_LEN   = 300;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_tick;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [mrftg_pkg::MASK_W-1:0] rsp_fired_mask;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [mrftg_pkg::MASK_W-1:0] csr_channel_enable;

   // shadow of the channel counters
   logic [mrftg_pkg::CNT_W-1:0]  frame_count [mrftg_pkg::MAX_CHANNELS];
   logic [mrftg_pkg::IDX_W-1:0]  frame_slot  [mrftg_pkg::MAX_CHANNELS];
   logic [mrftg_pkg::MASK_W-1:0] enable_shadow;

   logic [mrftg_pkg::MASK_W-1:0] fired_q [$];
   int                           errors;
   int                           idle_cycles;
   int                           send_idle_pct;
   int                           recv_stall_pct;
   int                           hold_left;
   bit                           hold_request;

   multi_rate_frame_tick_generator #(
      .CHANNELS(NUM_CH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_tick           (req_tick),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fired_mask     (rsp_fired_mask),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_channel_enable (csr_channel_enable)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [mrftg_pkg::IDX_W-1:0] frames_per_cycle(
      input logic [mrftg_pkg::CH_W-1:0] ch);
      logic [mrftg_pkg::IDX_W-1:0] n;
      n = 5'd1;
      case (ch)
         mrftg_pkg::CH_23976: n = 5'd24;
         mrftg_pkg::CH_24:    n = 5'd3;
         mrftg_pkg::CH_2997:  n = 5'd30;
         mrftg_pkg::CH_30:    n = 5'd3;
         mrftg_pkg::CH_48:    n = 5'd6;
         mrftg_pkg::CH_60:    n = 5'd3;
         default:             n = 5'd1;
      endcase
      return n;
   endfunction

   function automatic logic [mrftg_pkg::CNT_W-1:0] frame_ms(
      input logic [mrftg_pkg::CH_W-1:0]  ch,
      input logic [mrftg_pkg::IDX_W-1:0] slot);
      logic [mrftg_pkg::CNT_W-1:0] ms;
      ms = 6'd10;
      case (ch)
         mrftg_pkg::CH_23976: ms = (slot < 21 && slot % 3 == 2) ? 6'd41 : 6'd42;
         mrftg_pkg::CH_24:    ms = (slot == 2) ? 6'd41 : 6'd42;
         mrftg_pkg::CH_25:    ms = 6'd40;
         mrftg_pkg::CH_2997: begin
            if (slot < 27)
               ms = (slot % 3 == 2) ? 6'd34 : 6'd33;
            else
               ms = (slot == 27) ? 6'd33 : 6'd34;
         end
         mrftg_pkg::CH_30:    ms = (slot == 2) ? 6'd34 : 6'd33;
         mrftg_pkg::CH_48:    ms = (slot == 5) ? 6'd20 : 6'd21;
         mrftg_pkg::CH_60:    ms = (slot == 2) ? 6'd16 : 6'd17;
         default:             ms = 6'd10;
      endcase
      return ms;
   endfunction

   // advances the shadow counters by one beat and returns the frame mask
   function automatic logic [mrftg_pkg::MASK_W-1:0] next_fired_mask(input logic tick);
      logic [mrftg_pkg::MASK_W-1:0] mask;
      logic [mrftg_pkg::CNT_W-1:0]  cnt;
      logic [mrftg_pkg::IDX_W-1:0]  slot;
      mask = '0;
      if (tick) begin
         for (int c = 0; c < NUM_CH; c++) begin
            cnt = frame_count[c] - 1'b1;
            if (cnt == 0) begin
               slot = frame_slot[c] + 1'b1;
               if (enable_shadow[c])
                  mask[c] = 1'b1;
               if (slot >= frames_per_cycle(mrftg_pkg::CH_W'(c)))
                  slot = '0;
               frame_slot[c] = slot;
               cnt = frame_ms(mrftg_pkg::CH_W'(c), slot);
            end
            frame_count[c] = cnt;
         end
      end
      return mask;
   endfunction

   task automatic send_beat(input logic tick);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
      fired_q.push_back(next_fired_mask(tick));
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (fired_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_channel_enable(input logic [mrftg_pkg::MASK_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_channel_enable <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      enable_shadow = value;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // beats with no tick must leave every counter alone
   task automatic test_idle_ticks;
      set_idling(0, 0);
      repeat (3) send_beat(1'b0);
      wait_drained();
   endtask

   // first frames of the fast channels under the reset enable mask
   task automatic test_first_frames;
      set_idling(0, 0);
      repeat (10) send_beat(1'b1);
      send_beat(1'b0);
      repeat (10) send_beat(1'b1);
      wait_drained();
      write_channel_enable(mrftg_pkg::ENABLE_RESET);
   endtask

   task automatic test_random_phase(input int count, input int send_pct,
                                    input int recv_pct,
                                    input logic [mrftg_pkg::MASK_W-1:0] enable);
      write_channel_enable(enable);
      set_idling(send_pct, recv_pct);
      repeat (count) send_beat($urandom_range(9) != 0);
      wait_drained();
   endtask

   // output held off long enough that the block stalls its input
   task automatic test_output_backpressure;
      write_channel_enable(mrftg_pkg::ENABLE_RESET);
      set_idling(0, 15);
      hold_request = 1'b1;
      repeat (30) send_beat($urandom_range(9) != 0);
      wait_drained();
   endtask

   // steady ticks with light idling on both sides
   task automatic test_steady_ticks;
      write_channel_enable(mrftg_pkg::ENABLE_RESET);
      set_idling(15, 15);
      repeat (80) send_beat(1'b1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_LEN;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      logic [mrftg_pkg::MASK_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fired_q.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual %h", $time, rsp_fired_mask);
            errors++;
         end else begin
            want = fired_q.pop_front();
            if (rsp_fired_mask !== want) begin
               $display("%0t fired_mask mismatch: expected %h, actual %h",
                        $time, want, rsp_fired_mask);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_tick           = 1'b0;
      csr_valid          = 1'b0;
      csr_channel_enable = '0;
      errors             = 0;
      hold_request       = 1'b0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      enable_shadow      = mrftg_pkg::ENABLE_RESET;
      for (int c = 0; c < mrftg_pkg::MAX_CHANNELS; c++) begin
         frame_slot[c]  = '0;
         frame_count[c] = frame_ms(mrftg_pkg::CH_W'(c), '0);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_first_frames();
      test_random_phase(80, 0, 0, 8'h00);
      test_random_phase(80, 83, 0, 8'h55);
      test_random_phase(80, 0, 83, 8'hAA);
      test_random_phase(80, 15, 15, mrftg_pkg::MASK_W'($urandom_range(1, 254)));
      test_output_backpressure();
      test_steady_ticks();

      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
